// File: src/rtcva_pkg.sv
// rtcva_pkg: constants and helpers shared by the rtc time validate and advance block
// calendar limits, month codes, constant-divisor helpers and small bcd packing
// no dependencies
package rtcva_pkg;

	localparam int unsigned SEC_W  = 8;
	localparam int unsigned YEAR_W = 16;
	localparam int unsigned BCD_W  = 8;

	// calendar limits
	localparam logic [7:0]  SEC_MAX    = 8'd59;
	localparam logic [7:0]  MIN_MAX    = 8'd59;
	localparam logic [7:0]  HOUR_MAX   = 8'd23;
	localparam logic [7:0]  SEC_WRAP   = 8'd60;
	localparam logic [7:0]  MIN_WRAP   = 8'd60;
	localparam logic [7:0]  HOUR_WRAP  = 8'd24;
	localparam logic [15:0] YEAR_MIN   = 16'd1900;
	localparam logic [17:0] YEAR_BASE  = 18'd2000;

	// month codes
	localparam logic [7:0] MON_JAN = 8'd1;
	localparam logic [7:0] MON_FEB = 8'd2;
	localparam logic [7:0] MON_MAR = 8'd3;
	localparam logic [7:0] MON_APR = 8'd4;
	localparam logic [7:0] MON_JUN = 8'd6;
	localparam logic [7:0] MON_SEP = 8'd9;
	localparam logic [7:0] MON_NOV = 8'd11;
	localparam logic [7:0] MON_DEC = 8'd12;

	// day counts
	localparam logic [7:0] DAYS_LONG   = 8'd31;
	localparam logic [7:0] DAYS_SHORT  = 8'd30;
	localparam logic [7:0] DAYS_FEB_LP = 8'd29;
	localparam logic [7:0] DAYS_FEB    = 8'd28;

	// divisibility by 25 through the modular inverse of 25 mod 2^16
	localparam logic [15:0] INV25_16   = 16'd23593;
	localparam logic [15:0] DIV25_LIM  = 16'd2621;

	// reciprocal of ten for 16-bit operands, quotient is (n * RECIP10) >> RECIP10_SH
	localparam logic [16:0] RECIP10    = 17'd52429;
	localparam int unsigned RECIP10_SH = 19;

	// packs a value below 64 as tens*16 + ones
	function automatic logic [7:0] bcd_small(input logic [5:0] v);
		logic [3:0] tens;
		logic [5:0] rem;
		begin
			if (v >= 6'd60) begin
				tens = 4'd6;
			end else if (v >= 6'd50) begin
				tens = 4'd5;
			end else if (v >= 6'd40) begin
				tens = 4'd4;
			end else if (v >= 6'd30) begin
				tens = 4'd3;
			end else if (v >= 6'd20) begin
				tens = 4'd2;
			end else if (v >= 6'd10) begin
				tens = 4'd1;
			end else begin
				tens = 4'd0;
			end
			rem = v - 6'({tens, 3'b000} + {tens, 1'b0});
			return {tens, rem[3:0]};
		end
	endfunction

endpackage

// File: src/rtc_time_validate_advance_bcd.sv
// rtc_time_validate_advance_bcd: validates a date and time, advances it by a positive
// seconds offset with one minute carry at most, packs bcd bytes; depends on rtcva_pkg
// throughput: one beat per cycle while out_stall is low, input register -> single logic pass -> result register
// the result register holds a stalled beat while an empty input register still takes a new one
// reset: arst_n clears both stage valid flags at once, payload registers are not reset
module rtc_time_validate_advance_bcd (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      sec_in,
	input  logic [7:0]                      min_in,
	input  logic [7:0]                      hour_in,
	input  logic [7:0]                      day_in,
	input  logic [7:0]                      month_in,
	input  logic [rtcva_pkg::YEAR_W-1:0]    year_in,
	input  logic signed [7:0]               offset_sec,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            time_ok,
	output logic [rtcva_pkg::BCD_W-1:0]     sec_bcd,
	output logic [rtcva_pkg::BCD_W-1:0]     min_bcd,
	output logic [rtcva_pkg::BCD_W-1:0]     hour_bcd,
	output logic [rtcva_pkg::BCD_W-1:0]     date_bcd,
	output logic [rtcva_pkg::BCD_W-1:0]     month_bcd,
	output logic [rtcva_pkg::BCD_W-1:0]     year_bcd
);

	// stage 1: captured input beat
	logic                         valid_s1;
	logic [7:0]                   sec_s1;
	logic [7:0]                   min_s1;
	logic [7:0]                   hour_s1;
	logic [7:0]                   day_s1;
	logic [7:0]                   month_s1;
	logic [rtcva_pkg::YEAR_W-1:0] year_s1;
	logic signed [7:0]            offset_s1;

	// stage 2: result beat
	logic       valid_s2;
	logic       ok_s2;
	logic [7:0] sec_s2;
	logic [7:0] min_s2;
	logic [7:0] hour_s2;
	logic [7:0] date_s2;
	logic [7:0] month_s2;
	logic [7:0] year_s2;

	// handshake: result stage moves when empty or taken, input stage refills behind it
	logic adv_s2;
	logic load_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// validation
	// ---------------------------------------------------------------
	logic       year_div4;
	logic [7:0] month_len;
	logic       field_ok;
	logic       date_ok;

	// validation leap test is the simple multiple-of-four rule
	assign year_div4 = (year_s1[1:0] == 2'b00);

	always_comb begin
		case (month_s1) inside
			rtcva_pkg::MON_APR, rtcva_pkg::MON_JUN,
			rtcva_pkg::MON_SEP, rtcva_pkg::MON_NOV: begin
				month_len = rtcva_pkg::DAYS_SHORT;
			end
			rtcva_pkg::MON_FEB: begin
				month_len = year_div4 ? rtcva_pkg::DAYS_FEB_LP : rtcva_pkg::DAYS_FEB;
			end
			default: begin
				month_len = rtcva_pkg::DAYS_LONG;
			end
		endcase
	end

	assign field_ok = (sec_s1 <= rtcva_pkg::SEC_MAX) && (min_s1 <= rtcva_pkg::MIN_MAX) &&
			(hour_s1 <= rtcva_pkg::HOUR_MAX) && (year_s1 >= rtcva_pkg::YEAR_MIN) &&
			(month_s1 >= rtcva_pkg::MON_JAN) && (month_s1 <= rtcva_pkg::MON_DEC) &&
			(day_s1 != 8'd0);
	// an out of range month falls to the long length, but field_ok already rejects it
	assign date_ok  = field_ok && (day_s1 <= month_len);

	// ---------------------------------------------------------------
	// full gregorian leap rule, used only at the end of february
	// divisibility by 25 via multiply by the inverse of 25 modulo 2^16
	// ---------------------------------------------------------------
	logic [31:0] inv_prod;
	logic        year_div25;
	logic        greg_leap;
	logic [7:0]  feb_wrap;

	assign inv_prod   = 32'(year_s1) * 32'(rtcva_pkg::INV25_16);
	assign year_div25 = (inv_prod[15:0] <= rtcva_pkg::DIV25_LIM);
	// divisible by 400 means divisible by 16 and by 25; by 100 means by 4 and by 25
	assign greg_leap  = ((year_s1[3:0] == 4'd0) && year_div25) || (year_div4 && !year_div25);
	// day number that rolls february over into march
	assign feb_wrap   = greg_leap ? rtcva_pkg::DAYS_SHORT : rtcva_pkg::DAYS_FEB_LP;

	// ---------------------------------------------------------------
	// advance: seconds modulo 60, then a ripple of at most one minute
	// ---------------------------------------------------------------
	logic        off_pos;
	logic [8:0]  sec_sum;
	logic [8:0]  sec_mod;
	logic        carry_sec;
	logic        carry_min;
	logic        carry_hour;
	logic [7:0]  sec_n;
	logic [7:0]  min_n;
	logic [7:0]  hour_n;
	logic [7:0]  day_n;
	logic [7:0]  month_n;
	logic [16:0] year_n;

	assign off_pos = !offset_s1[7] && (offset_s1 != 8'sd0);
	assign sec_sum = 9'(sec_s1) + 9'(offset_s1[6:0]);

	// sum stays below 180 + 60 for valid input, so three compare and subtract steps cover it
	always_comb begin
		if (sec_sum >= 9'd180) begin
			sec_mod = sec_sum - 9'd180;
		end else if (sec_sum >= 9'd120) begin
			sec_mod = sec_sum - 9'd120;
		end else if (sec_sum >= 9'(rtcva_pkg::SEC_WRAP)) begin
			sec_mod = sec_sum - 9'(rtcva_pkg::SEC_WRAP);
		end else begin
			sec_mod = sec_sum;
		end
	end

	always_comb begin
		sec_n      = sec_s1;
		min_n      = min_s1;
		hour_n     = hour_s1;
		day_n      = day_s1;
		month_n    = month_s1;
		year_n     = 17'(year_s1);
		carry_sec  = 1'b0;
		carry_min  = 1'b0;
		carry_hour = 1'b0;

		if (off_pos) begin
			sec_n     = sec_mod[7:0];
			carry_sec = (sec_sum >= 9'(rtcva_pkg::SEC_WRAP));
		end

		if (carry_sec) begin
			min_n = min_s1 + 8'd1;
			if (min_n == rtcva_pkg::MIN_WRAP) begin
				min_n     = 8'd0;
				carry_min = 1'b1;
			end
		end

		if (carry_min) begin
			hour_n = hour_s1 + 8'd1;
			if (hour_n == rtcva_pkg::HOUR_WRAP) begin
				hour_n     = 8'd0;
				carry_hour = 1'b1;
			end
		end

		if (carry_hour) begin
			day_n = day_s1 + 8'd1;
			case (month_s1) inside
				rtcva_pkg::MON_APR, rtcva_pkg::MON_JUN,
				rtcva_pkg::MON_SEP, rtcva_pkg::MON_NOV: begin
					if (day_n == rtcva_pkg::DAYS_LONG) begin
						day_n   = 8'd1;
						month_n = month_s1 + 8'd1;
					end
				end
				rtcva_pkg::MON_FEB: begin
					// february 29 of a non-gregorian leap year moves on to the 30th
					if (day_n == feb_wrap) begin
						day_n   = 8'd1;
						month_n = rtcva_pkg::MON_MAR;
					end
				end
				default: begin
					if (day_n == rtcva_pkg::DAYS_LONG + 8'd1) begin
						day_n = 8'd1;
						if (month_s1 == rtcva_pkg::MON_DEC) begin
							month_n = rtcva_pkg::MON_JAN;
							// no wrap at the top of the year range
							year_n  = 17'(year_s1) + 17'd1;
						end else begin
							month_n = month_s1 + 8'd1;
						end
					end
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// year byte: truncating split of (year - 2000) into tens and ones
	// ---------------------------------------------------------------
	logic [17:0] year_off;
	logic        year_neg;
	logic [15:0] year_mag;
	logic [32:0] q_prod;
	logic [15:0] year_q;
	logic [15:0] year_r;
	logic [7:0]  year_pack;

	assign year_off = 18'(year_n) - rtcva_pkg::YEAR_BASE;
	assign year_neg = year_off[17];
	// magnitude never exceeds 63536, so 16 bits hold it
	assign year_mag = year_neg ? 16'(18'd0 - year_off) : year_off[15:0];
	assign q_prod   = 33'(year_mag) * 33'(rtcva_pkg::RECIP10);
	assign year_q   = 16'(q_prod >> rtcva_pkg::RECIP10_SH);
	assign year_r   = year_mag - 16'({year_q, 3'b000} + {year_q, 1'b0});
	// only the low nibble of the quotient survives the 8-bit truncation
	assign year_pack = year_neg ? 8'(8'd0 - {year_q[3:0], year_r[3:0]})
			: {year_q[3:0], year_r[3:0]};

	// ---------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || adv_s2) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sec_s1    <= sec_in;
			min_s1    <= min_in;
			hour_s1   <= hour_in;
			day_s1    <= day_in;
			month_s1  <= month_in;
			year_s1   <= year_in;
			offset_s1 <= offset_sec;
		end
	end

	// invalid input clears every byte of the result
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			ok_s2    <= date_ok;
			sec_s2   <= date_ok ? rtcva_pkg::bcd_small(sec_n[5:0]) : 8'd0;
			min_s2   <= date_ok ? rtcva_pkg::bcd_small(min_n[5:0]) : 8'd0;
			hour_s2  <= date_ok ? rtcva_pkg::bcd_small(hour_n[5:0]) : 8'd0;
			date_s2  <= date_ok ? rtcva_pkg::bcd_small(day_n[5:0]) : 8'd0;
			month_s2 <= date_ok ? rtcva_pkg::bcd_small(month_n[5:0]) : 8'd0;
			year_s2  <= date_ok ? year_pack : 8'd0;
		end
	end

	assign out_valid = valid_s2;
	assign time_ok   = ok_s2;
	assign sec_bcd   = sec_s2;
	assign min_bcd   = min_s2;
	assign hour_bcd  = hour_s2;
	assign date_bcd  = date_s2;
	assign month_bcd = month_s2;
	assign year_bcd  = year_s2;

endmodule
